// ===== rtl/core/nv2r_pkg.sv =====
// Shared types and constants of the NV21 to RGB converter.
package nv2r_pkg;

  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [CfgIndexW-1:0] CfgFrameWidth  = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgFrameHeight = 1'b1;

  localparam logic [CfgDataW-1:0] FrameWidthReset  = 13'd640;
  localparam logic [CfgDataW-1:0] FrameHeightReset = 13'd480;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam int unsigned ProdW  = 21;
  localparam int unsigned MultiW = 19;
  localparam int unsigned SumW   = 13;

  localparam logic [7:0] LumaFloor = 8'd16;

  localparam logic [MultiW-1:0]       CoefY  = 19'd1192;
  localparam logic signed [ProdW-1:0] CoefRV = 21'sd1634;
  localparam logic signed [ProdW-1:0] CoefGV = 21'sd833;
  localparam logic signed [ProdW-1:0] CoefGU = 21'sd400;
  localparam logic signed [ProdW-1:0] CoefBU = 21'sd2066;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_v;
    logic [7:0] chroma_u;
    logic       end_of_row;
    logic       end_of_frame;
  } item_t;

endpackage

// ===== rtl/core/nv2r_front.sv =====
// Front end: registers, raster counters, chroma line buffer and pair selection.
module nv2r_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     luma_i,
  input  logic [7:0]                     chroma_v_i,
  input  logic [7:0]                     chroma_u_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nv2r_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [nv2r_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           item_valid_o,
  output nv2r_pkg::item_t                item_o,
  input  logic                           fifo_full_i
);
  import nv2r_pkg::*;

  localparam int unsigned ColW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned Depth = MAX_WIDTH / 2;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [13:0] MaxW  = 14'(MAX_WIDTH);
  localparam logic [13:0] MaxH  = 14'(MAX_HEIGHT);
  localparam logic [13:0] LastIdx = 14'(Depth - 1);

  logic [CfgDataW-1:0] frame_width_q, frame_height_q;
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [15:0]         pair_cur_q, pair_cur_d;
  logic [15:0]         line_mem [Depth];
  logic [15:0]         rd_q;
  logic                s1_valid_q, s1_valid_d;
  logic                s1_use_mem_q;
  logic [15:0]         s1_pair_q;
  logic [7:0]          s1_luma_q;
  logic                s1_eor_q, s1_eof_q;

  logic        accept, push, eor, last_row, odd_row, odd_col, wr_en;
  logic [13:0] w_raw, w_eff, h_eff, idx_full;
  logic [AddrW-1:0] idx;
  logic [15:0] pair_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthReset;
      frame_height_q <= FrameHeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFrameWidth:  frame_width_q  <= cfg_data_i;
        CfgFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_raw = {1'b0, frame_width_q[CfgDataW-1:1], 1'b0};
    if (w_raw < 14'd2) begin
      w_eff = 14'd2;
    end else if (w_raw > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = w_raw;
    end
    if (frame_height_q == '0) begin
      h_eff = 14'd1;
    end else if (14'(frame_height_q) > MaxH) begin
      h_eff = MaxH;
    end else begin
      h_eff = 14'(frame_height_q);
    end
    idx_full = 14'(col_q) >> 1;
    if (idx_full > LastIdx) begin
      idx_full = LastIdx;
    end
    idx = idx_full[AddrW-1:0];
  end

  assign in_stall_o = s1_valid_q && fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = s1_valid_q && !fifo_full_i;
  assign eor        = 14'(col_q) >= (w_eff - 14'd1);
  assign last_row   = 14'(row_q) >= (h_eff - 14'd1);
  assign odd_row    = row_q[0];
  assign odd_col    = col_q[0];
  assign wr_en      = accept && !odd_row && !odd_col;

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    pair_cur_d = pair_cur_q;
    if (accept) begin
      if (eor) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
      if (wr_en) begin
        pair_cur_d = {chroma_v_i, chroma_u_i};
      end
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pair_cur_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      pair_cur_q <= pair_cur_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[idx] <= {chroma_v_i, chroma_u_i};
    end
    if (accept) begin
      rd_q <= line_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_luma_q    <= luma_i;
      s1_use_mem_q <= odd_row;
      s1_pair_q    <= odd_col ? pair_cur_q : {chroma_v_i, chroma_u_i};
      s1_eor_q     <= eor;
      s1_eof_q     <= eor && last_row;
    end
  end

  assign pair_out = s1_use_mem_q ? rd_q : s1_pair_q;

  assign item_valid_o         = push;
  assign item_o.luma          = s1_luma_q;
  assign item_o.chroma_v      = pair_out[15:8];
  assign item_o.chroma_u      = pair_out[7:0];
  assign item_o.end_of_row    = s1_eor_q;
  assign item_o.end_of_frame  = s1_eof_q;

endmodule

// ===== rtl/core/nv2r_fifo.sv =====
// Short request queue between the front end and the color pipeline.
module nv2r_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nv2r_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output nv2r_pkg::item_t pop_item_o
);
  import nv2r_pkg::*;

  item_t               slots_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                do_pop;

  assign full_o     = count_q == FifoCntW'(FifoDepth);
  assign valid_o    = count_q != '0;
  assign do_pop     = pop_i && valid_o;
  assign pop_item_o = slots_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + FifoCntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/nv2r_back.sv =====
// Color pipeline: Q10 products, sums, saturation and the output register.
module nv2r_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  nv2r_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic            end_of_row_o,
  output logic            end_of_frame_o
);
  import nv2r_pkg::*;

  logic                     en;
  logic                     a_valid_q, out_valid_q;
  logic [MultiW-1:0]        pm_q, pm_d;
  logic signed [ProdW-1:0]  pr_q, pgv_q, pgu_q, pb_q;
  logic signed [ProdW-1:0]  pr_d, pgv_d, pgu_d, pb_d;
  logic                     a_eor_q, a_eof_q;
  logic [MultiW-1:0]        y_ext;
  logic signed [ProdW-1:0]  v_ext, u_ext;
  logic [7:0]               y_cl;
  logic signed [SumW-1:0]   multi, r_sum, g_sum, b_sum;
  logic [7:0]               red_q, green_q, blue_q;
  logic                     eor_q, eof_q;

  function automatic logic [7:0] sat8(input logic signed [SumW-1:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 13'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  function automatic logic signed [SumW-1:0] floor_q10(input logic signed [ProdW-1:0] p);
    return {{(SumW - (ProdW - 10)){p[ProdW-1]}}, p[ProdW-1:10]};
  endfunction

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = item_valid_i && en;

  always_comb begin
    y_cl  = (item_i.luma < LumaFloor) ? LumaFloor : item_i.luma;
    y_ext = MultiW'(y_cl - LumaFloor);
    v_ext = {{(ProdW - 8){~item_i.chroma_v[7]}}, ~item_i.chroma_v[7], item_i.chroma_v[6:0]};
    u_ext = {{(ProdW - 8){~item_i.chroma_u[7]}}, ~item_i.chroma_u[7], item_i.chroma_u[6:0]};
    pm_d  = y_ext * CoefY;
    pr_d  = v_ext * CoefRV;
    pgv_d = v_ext * CoefGV;
    pgu_d = u_ext * CoefGU;
    pb_d  = u_ext * CoefBU;
  end

  always_comb begin
    multi = SumW'(pm_q[MultiW-1:10]);
    r_sum = multi + floor_q10(pr_q);
    g_sum = multi - floor_q10(pgv_q) - floor_q10(pgu_q);
    b_sum = multi + floor_q10(pb_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= item_valid_i;
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_q    <= pm_d;
      pr_q    <= pr_d;
      pgv_q   <= pgv_d;
      pgu_q   <= pgu_d;
      pb_q    <= pb_d;
      a_eor_q <= item_i.end_of_row;
      a_eof_q <= item_i.end_of_frame;
      red_q   <= sat8(r_sum);
      green_q <= sat8(g_sum);
      blue_q  <= sat8(b_sum);
      eor_q   <= a_eor_q;
      eof_q   <= a_eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign end_of_row_o   = eor_q;
  assign end_of_frame_o = eof_q;

endmodule

// ===== rtl/core/nv21_to_rgb_converter_unit.sv =====
// Top level of the NV21 to BT.601 RGB converter.
// Takes one NV21 pixel and gives one RGB pixel per clock, sustained, while
// out_stall_i is low. A pixel reaches the output register through the front
// stage (counters and the registered line buffer read), the four-entry request
// queue and the product stage of the color pipeline, whose sums and saturation
// then load the output register. The pair for odd rows comes from a line buffer
// of MAX_WIDTH/2 entries written on even rows; entries are not cleared after
// reset.
// frame_width and frame_height are written through the configuration port,
// which is always ready, and are meant to change only while the block is idle.
module nv21_to_rgb_converter_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     luma_i,
  input  logic [7:0]                     chroma_v_i,
  input  logic [7:0]                     chroma_u_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic                           end_of_row_o,
  output logic                           end_of_frame_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nv2r_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [nv2r_pkg::CfgDataW-1:0]  cfg_data_i
);
  import nv2r_pkg::*;

  logic  push, full, pop, q_valid;
  item_t push_item, pop_item;

  nv2r_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .luma_i      (luma_i),
    .chroma_v_i  (chroma_v_i),
    .chroma_u_i  (chroma_u_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_valid_o(push),
    .item_o      (push_item),
    .fifo_full_i (full)
  );

  nv2r_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_item_o (pop_item)
  );

  nv2r_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .end_of_row_o  (end_of_row_o),
    .end_of_frame_o(end_of_frame_o)
  );

endmodule
